// ----- rtl/core/tcw_pkg.sv -----
`timescale 1ns / 1ps

package tcw_pkg;

	// one screen cell: colour byte above character byte
	typedef struct packed {
		logic [7:0] colour;
		logic [7:0] chr;
	} cell_t;

	localparam cell_t BLANK_CELL = '{colour: 8'h00, chr: 8'h20};

	localparam logic [7:0] LINE_FEED = 8'd10;

	typedef enum logic [1:0] {
		ACT_PUT   = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_READ  = 2'd2
	} action_t;

	typedef enum logic {
		CFG_FOREGROUND = 1'b0,
		CFG_BACKGROUND = 1'b1
	} cfg_reg_t;

endpackage

// ----- rtl/core/tcw_cell_store.sv -----
`timescale 1ns / 1ps

module tcw_cell_store
	import tcw_pkg::*;
#(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  cell_t         wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output cell_t         rd_data
);

	cell_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/core/text_console_writer_unit.sv -----
`timescale 1ns / 1ps

// Text console writer: a ROWS x COLUMNS store of 16-bit cells (colour byte over character
// byte) and a cursor. A put beat writes its byte at the cursor with the current colours and
// moves the cursor right; byte 10 is a line feed; a byte that finds the cursor one past the
// last column wraps first; a line feed or a wrap on the bottom row scrolls the screen up one
// row and blanks the bottom row. A clear beat blanks every cell and keeps the cursor. A read
// beat returns one cell (zeros when the row or column is off screen). Every input beat yields
// exactly one result beat carrying the cursor after the beat. A new input beat is taken
// only once the result of the last one has gone into the result register. The block rests on
// the single store that takes one write and one read a cycle and is walked cell by cell by
// one sweep counter, shared by init, clear and scroll, and on the row-times-columns address
// unit that registers the cell address before each store access. After reset the block
// walks the store once to blank it with s_tready low; configuration writes are taken at any time.
module text_console_writer_unit
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // char_code[7:0], read_row[12:8], read_col[19:13], zero pad
	input  logic [1:0]  s_tuser,   // action[1:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // cell_char[7:0], cell_colour[15:8], cursor_row[20:16],
	                               // cursor_col[27:21], zero pad
	// colour register writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int RW    = $clog2(ROWS);
	localparam int CW    = $clog2(COLUMNS + 1);

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCROLL,
		ST_BLANK,
		ST_ADDR,
		ST_WRITE,
		ST_READ,
		ST_CLEAR,
		ST_DONE
	} state_t;

	state_t state_q;

	// cursor
	logic [RW-1:0] row_q;
	logic [CW-1:0] col_q;

	// colour registers
	logic [3:0] fg_q;
	logic [3:0] bg_q;

	// latched beat
	action_t     act_q;
	logic [7:0]  char_q;
	logic [4:0]  rrow_q;
	logic [6:0]  rcol_q;
	logic        rd_ok_q;     // read beat that lands on screen
	logic        wr_pend_q;   // wrap done, character still to be written

	// sweep counter shared by init, clear and scroll, and the cell address
	logic [AW-1:0] sweep_q;
	logic [AW-1:0] addr_q;

	// scroll copy: read one row down, write here in the next cycle
	logic          copy_s1;
	logic [AW-1:0] dst_s1;

	// result register
	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;

	// store port
	logic          st_wr_en;
	logic [AW-1:0] st_wr_addr;
	cell_t         st_wr_data;
	logic          st_rd_en;
	logic [AW-1:0] st_rd_addr;
	cell_t         st_rd_data;

	// input fields
	action_t    in_act;
	logic [7:0] in_char;
	logic [4:0] in_rrow;
	logic [6:0] in_rcol;
	logic       in_on_screen;
	logic       in_accept;

	// address unit operands
	logic [RW-1:0] sel_row;
	logic [CW-1:0] sel_col;

	assign in_act       = action_t'(s_tuser);
	assign in_char      = s_tdata[7:0];
	assign in_rrow      = s_tdata[12:8];
	assign in_rcol      = s_tdata[19:13];
	assign in_on_screen = (32'(in_rrow) < ROWS) && (32'(in_rcol) < COLUMNS);

	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// read beats address the requested cell, puts the cursor cell
	always_comb begin
		if (act_q == ACT_READ) begin
			sel_row = RW'(rrow_q);
			sel_col = CW'(rcol_q);
		end else begin
			sel_row = row_q;
			sel_col = col_q;
		end
	end

	// store port steering; a pending scroll copy owns the write port
	always_comb begin
		st_wr_en   = 1'b0;
		st_wr_addr = sweep_q;
		st_wr_data = BLANK_CELL;
		st_rd_en   = 1'b0;
		st_rd_addr = sweep_q;
		if (copy_s1) begin
			st_wr_en   = 1'b1;
			st_wr_addr = dst_s1;
			st_wr_data = st_rd_data;
		end else begin
			case (state_q)
				ST_INIT, ST_CLEAR, ST_BLANK: begin
					st_wr_en = 1'b1;
				end
				ST_WRITE: begin
					st_wr_en   = 1'b1;
					st_wr_addr = addr_q;
					st_wr_data = '{colour: {bg_q, fg_q}, chr: char_q};
				end
				default: begin
				end
			endcase
		end
		case (state_q)
			ST_SCROLL: st_rd_en = 1'b1;
			ST_READ: begin
				st_rd_en   = 1'b1;
				st_rd_addr = addr_q;
			end
			default: begin
			end
		endcase
	end

	tcw_cell_store #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_store (
		.clk    (clk),
		.wr_en  (st_wr_en),
		.wr_addr(st_wr_addr),
		.wr_data(st_wr_data),
		.rd_en  (st_rd_en),
		.rd_addr(st_rd_addr),
		.rd_data(st_rd_data)
	);

	// colour registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= 4'd15;
			bg_q <= 4'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FOREGROUND: fg_q <= cfg_data;
				CFG_BACKGROUND: bg_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// payload of the scroll copy stage
	always_ff @(posedge clk) begin
		if (state_q == ST_SCROLL) begin
			dst_s1 <= sweep_q - AW'(COLUMNS);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			row_q      <= '0;
			col_q      <= '0;
			sweep_q    <= '0;
			copy_s1    <= 1'b0;
			wr_pend_q  <= 1'b0;
			rd_ok_q    <= 1'b0;
			act_q      <= ACT_PUT;
			char_q     <= '0;
			rrow_q     <= '0;
			rcol_q     <= '0;
			addr_q     <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			copy_s1 <= 1'b0;
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				// blank the store once after reset
				ST_INIT: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == AW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_accept) begin
						act_q     <= in_act;
						char_q    <= in_char;
						rrow_q    <= in_rrow;
						rcol_q    <= in_rcol;
						rd_ok_q   <= (in_act == ACT_READ) && in_on_screen;
						wr_pend_q <= 1'b0;
						case (in_act)
							ACT_PUT: begin
								if (in_char == LINE_FEED) begin
									col_q <= '0;
									if (row_q < RW'(ROWS - 1)) begin
										row_q   <= row_q + RW'(1);
										state_q <= ST_DONE;
									end else begin
										sweep_q <= AW'(COLUMNS);
										state_q <= ST_SCROLL;
									end
								end else if (col_q == CW'(COLUMNS)) begin
									// wrap before writing
									col_q     <= '0;
									wr_pend_q <= 1'b1;
									if (row_q < RW'(ROWS - 1)) begin
										row_q   <= row_q + RW'(1);
										state_q <= ST_ADDR;
									end else begin
										sweep_q <= AW'(COLUMNS);
										state_q <= ST_SCROLL;
									end
								end else begin
									state_q <= ST_ADDR;
								end
							end
							ACT_CLEAR: begin
								sweep_q <= '0;
								state_q <= ST_CLEAR;
							end
							ACT_READ: begin
								state_q <= in_on_screen ? ST_ADDR : ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				// move rows 1..last up one row
				ST_SCROLL: begin
					copy_s1 <= 1'b1;
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == AW'(CELLS - 1)) begin
						sweep_q <= AW'(CELLS - COLUMNS);
						state_q <= ST_BLANK;
					end
				end
				// blank the bottom row once the last copy has landed
				ST_BLANK: begin
					if (!copy_s1) begin
						sweep_q <= sweep_q + AW'(1);
						if (sweep_q == AW'(CELLS - 1)) begin
							state_q <= wr_pend_q ? ST_ADDR : ST_DONE;
						end
					end
				end
				ST_ADDR: begin
					addr_q  <= AW'(AW'(sel_row) * AW'(COLUMNS)) + AW'(sel_col);
					state_q <= (act_q == ACT_READ) ? ST_READ : ST_WRITE;
				end
				ST_WRITE: begin
					col_q   <= col_q + CW'(1);
					state_q <= ST_DONE;
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_CLEAR: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == AW'(CELLS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				// hand the result over once the result register is free
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {4'd0, 7'(col_q), 5'(row_q),
						               rd_ok_q ? st_rd_data.colour : 8'd0,
						               rd_ok_q ? st_rd_data.chr : 8'd0};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/tcw_checker.sv -----
`timescale 1ns / 1ps

module tcw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// one beat at a time: busy right after an accepted beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again right after a beat");

	// cursor never leaves the screen (wrap pending at most)
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[27:21]) <= COLUMNS) && (32'(m_tdata[20:16]) < ROWS))
		else $error("cursor off screen");

	// padding bits stay clear
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[31:28] == 4'd0))
		else $error("result padding not zero");

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

endmodule

bind text_console_writer_unit tcw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tcw_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

// ----- dv/tb_text_console_writer_unit.sv -----
`timescale 1ns / 1ps

module tb_text_console_writer_unit;
	import tcw_pkg::*;

	// screen geometry, as the dut is built
	localparam int COLS  = 80;
	localparam int ROWS  = 25;
	localparam int CELLS = COLS * ROWS;

	// the action code that the package leaves out: the block must ignore it
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	// longest run of cycles with no beat on any channel before we give up:
	// a clear or a scroll walks the whole store, the receiver may stall for a
	// whole pattern window and the sender may sit in a gap, all taken a few times
	localparam int STALL_LIMIT = 4 * (2 * CELLS + 256);

	// one result beat, packed exactly as m_tdata[27:0]
	typedef struct packed {
		logic [6:0] col;
		logic [4:0] row;
		logic [7:0] colour;
		logic [7:0] chr;
	} cell_report_t;

	// one row of the directed sequence: either a colour write or an input beat,
	// the latter with a hand-written result where it is obvious
	typedef struct packed {
		logic       is_cfg;
		cfg_reg_t   cfg_sel;
		logic [3:0] cfg_val;
		logic [1:0] act;
		logic [7:0] chr;
		logic [4:0] rrow;
		logic [6:0] rcol;
		logic       typed;
		logic [7:0] e_chr;
		logic [7:0] e_colour;
		logic [4:0] e_row;
		logic [6:0] e_col;
	} console_step_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // char_code[7:0], read_row[12:8], read_col[19:13], zero pad
	logic [1:0]  s_tuser;   // action[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // cell_char[7:0], cell_colour[15:8], cursor_row[20:16],
	                        // cursor_col[27:21], zero pad
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [3:0]  cfg_data;

	text_console_writer_unit #(
		.COLUMNS(COLS),
		.ROWS   (ROWS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 8 ns period: invert every half period
	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// shadow copy of the console: character and colour planes, cursor and
	// the two colour nibbles, updated as each beat is accepted
	// ------------------------------------------------------------------
	logic [7:0]  screen_chr [0:CELLS-1];
	logic [7:0]  screen_clr [0:CELLS-1];
	int unsigned cursor_r;
	int unsigned cursor_c;
	logic [3:0]  fg_nibble;
	logic [3:0]  bg_nibble;

	// results still owed by the dut, oldest first
	cell_report_t pending_reports [$];

	int unsigned beats_sent;
	int unsigned burst_left;
	int          mismatches;
	int          quiet_cycles;
	bit          beat_offered;    // s_tvalid has been raised and not yet lowered
	bit          colour_offered;  // same for cfg_valid

	function automatic void blank_rows(input int unsigned first, input int unsigned last);
		for (int unsigned i = first * COLS; i < (last + 1) * COLS; i++) begin
			screen_chr[i] = BLANK_CELL.chr;
			screen_clr[i] = BLANK_CELL.colour;
		end
	endfunction

	// line feed: back to column 0, next row, or scroll when already on the bottom row
	function automatic void advance_line();
		cursor_c = 0;
		if (cursor_r < ROWS - 1) begin
			cursor_r++;
		end else begin
			for (int unsigned i = 0; i < CELLS - COLS; i++) begin
				screen_chr[i] = screen_chr[i + COLS];
				screen_clr[i] = screen_clr[i + COLS];
			end
			blank_rows(ROWS - 1, ROWS - 1);
		end
	endfunction

	// what the console answers to one input beat, with the shadow state moved on
	function automatic cell_report_t apply_console_beat(input logic [1:0] act,
		input logic [7:0] ch, input logic [4:0] rr, input logic [6:0] rc);
		cell_report_t rep;
		int unsigned  idx;
		rep = '0;
		case (act)
			ACT_PUT: begin
				if (ch == LINE_FEED) begin
					advance_line();
				end else begin
					// a pending wrap is taken before the character lands
					if (cursor_c >= COLS)
						advance_line();
					idx = cursor_r * COLS + cursor_c;
					screen_chr[idx] = ch;
					screen_clr[idx] = {bg_nibble, fg_nibble};
					cursor_c++;
				end
			end
			ACT_CLEAR: begin
				blank_rows(0, ROWS - 1);
			end
			ACT_READ: begin
				// off-screen reads answer zeros
				if (rr < ROWS && rc < COLS) begin
					idx = rr * COLS + rc;
					rep.chr    = screen_chr[idx];
					rep.colour = screen_clr[idx];
				end
			end
			default: ;
		endcase
		rep.row = cursor_r[4:0];
		rep.col = cursor_c[6:0];
		return rep;
	endfunction

	// ------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------

	// offer one beat; the sender works in bursts with random gaps between them
	task automatic send_beat(input logic [1:0] act, input logic [7:0] ch,
		input logic [4:0] rr, input logic [6:0] rc,
		input logic typed, input cell_report_t typed_rep);
		int unsigned  gap;
		cell_report_t predicted;
		if (colour_offered) begin
			cfg_valid <= 1'b0;
			colour_offered = 1'b0;
		end
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			if (gap != 0) begin
				if (beat_offered) begin
					s_tvalid <= 1'b0;
					beat_offered = 1'b0;
				end
				repeat (gap) @(posedge clk);
			end
			// mostly short bursts, now and then a long stretch with no gaps at all
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 12);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0000, rc, rr, ch};
		s_tuser  <= act;
		beat_offered = 1'b1;
		do @(posedge clk); while (!s_tready);
		predicted = apply_console_beat(act, ch, rr, rc);
		pending_reports.push_back(typed ? typed_rep : predicted);
		beats_sent++;
	endtask

	task automatic feed(input logic [1:0] act, input logic [7:0] ch,
		input logic [4:0] rr, input logic [6:0] rc);
		send_beat(act, ch, rr, rc, 1'b0, '0);
	endtask

	// put beats carry junk in the read fields, which the block must ignore
	task automatic put_byte(input logic [7:0] ch);
		feed(ACT_PUT, ch, 5'($urandom), 7'($urandom));
	endtask

	task automatic read_at(input logic [4:0] rr, input logic [6:0] rc);
		feed(ACT_READ, 8'($urandom), rr, rc);
	endtask

	// mostly cells on the cursor row, where fresh text sits, some anywhere,
	// some with the row or the column off screen
	task automatic read_random();
		int unsigned s;
		s = $urandom_range(0, 9);
		if (s < 5)
			read_at(5'(cursor_r), 7'($urandom_range(0, COLS - 1)));
		else if (s < 8)
			read_at(5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLS - 1)));
		else if (s == 8)
			read_at(5'($urandom_range(ROWS, 31)), 7'($urandom_range(0, 127)));
		else
			read_at(5'($urandom_range(0, 31)), 7'($urandom_range(COLS, 127)));
	endtask

	// any byte but line feed
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		b = 8'($urandom);
		if (b == LINE_FEED)
			b = b ^ 8'h01;
		return b;
	endfunction

	// hold the input back until the dut has answered everything
	task automatic wait_for_results();
		if (beat_offered) begin
			s_tvalid <= 1'b0;
			beat_offered = 1'b0;
		end
		while (pending_reports.size() != 0) @(posedge clk);
	endtask

	task automatic write_colour(input cfg_reg_t sel, input logic [3:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		colour_offered = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (sel == CFG_FOREGROUND)
			fg_nibble = val;
		else
			bg_nibble = val;
	endtask

	// random traffic made of short scenes: lines of text, lines filled to the
	// edge so that a wrap is left pending, runs of line feeds that push the
	// screen into scrolling, reads, clears and the odd unused action
	task automatic run_random(input int unsigned target);
		int unsigned pick;
		int unsigned n;
		int unsigned j;
		while (beats_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 30) begin
				n = $urandom_range(1, 90);
				for (j = 0; j < n; j++)
					put_byte(plain_byte());
				if ($urandom_range(0, 1))
					put_byte(LINE_FEED);
			end else if (pick < 45) begin
				// fill to the last column, look at it, then wrap or break the line
				n = COLS - cursor_c;
				for (j = 0; j < n; j++)
					put_byte(plain_byte());
				read_at(5'(cursor_r), 7'(COLS - 1));
				put_byte($urandom_range(0, 1) ? plain_byte() : LINE_FEED);
			end else if (pick < 65) begin
				n = $urandom_range(1, 6);
				for (j = 0; j < n; j++)
					read_random();
			end else if (pick < 80) begin
				// line feeds, then a look at the bottom rows after any scroll
				n = $urandom_range(1, 8);
				for (j = 0; j < n; j++)
					put_byte(LINE_FEED);
				read_at(5'(ROWS - 1), 7'($urandom_range(0, COLS - 1)));
				read_at(5'(ROWS - 2), 7'($urandom_range(0, COLS - 1)));
			end else if (pick < 88) begin
				put_byte(8'($urandom));
			end else if (pick < 94) begin
				feed(ACT_UNUSED, 8'($urandom), 5'($urandom), 7'($urandom));
			end else begin
				feed(ACT_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
				read_random();
			end
			// now and then let the output side drain completely
			if ($urandom_range(0, 149) == 0)
				wait_for_results();
		end
	endtask

	// directed opening: reset contents, corners, off-screen reads, the unused
	// action, extreme bytes, line feed, colour extremes, clear
	console_step_t directed_steps [0:24] = '{
		// reset contents at both corners
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_READ,   8'h00, 5'd0,  7'd0,   1'b1, 8'h20, 8'h00, 5'd0, 7'd0},
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_READ,   8'hFF, 5'd24, 7'd79,  1'b1, 8'h20, 8'h00, 5'd0, 7'd0},
		// off-screen reads answer zeros
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_READ,   8'h00, 5'd25, 7'd0,   1'b1, 8'h00, 8'h00, 5'd0, 7'd0},
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_READ,   8'h00, 5'd31, 7'd127, 1'b1, 8'h00, 8'h00, 5'd0, 7'd0},
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_READ,   8'h00, 5'd0,  7'd80,  1'b1, 8'h00, 8'h00, 5'd0, 7'd0},
		// unused action changes nothing
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_UNUSED, 8'hFF, 5'd31, 7'd127, 1'b1, 8'h00, 8'h00, 5'd0, 7'd0},
		// extreme bytes in reset colours
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_PUT,    8'h00, 5'd31, 7'd127, 1'b1, 8'h00, 8'h00, 5'd0, 7'd1},
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_PUT,    8'hFF, 5'd0,  7'd0,   1'b1, 8'h00, 8'h00, 5'd0, 7'd2},
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_READ,   8'h00, 5'd0,  7'd0,   1'b1, 8'h00, 8'h0F, 5'd0, 7'd2},
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_READ,   8'h00, 5'd0,  7'd1,   1'b1, 8'hFF, 8'h0F, 5'd0, 7'd2},
		// line feed mid-screen
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_PUT,    8'h0A, 5'd0,  7'd0,   1'b1, 8'h00, 8'h00, 5'd1, 7'd0},
		// colours swapped to the opposite extremes
		'{1'b1, CFG_FOREGROUND, 4'd0,  ACT_PUT,    8'h00, 5'd0,  7'd0,   1'b0, 8'h00, 8'h00, 5'd0, 7'd0},
		'{1'b1, CFG_BACKGROUND, 4'd15, ACT_PUT,    8'h00, 5'd0,  7'd0,   1'b0, 8'h00, 8'h00, 5'd0, 7'd0},
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_PUT,    8'h41, 5'd0,  7'd0,   1'b1, 8'h00, 8'h00, 5'd1, 7'd1},
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_READ,   8'h00, 5'd1,  7'd0,   1'b1, 8'h41, 8'hF0, 5'd1, 7'd1},
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_PUT,    8'h0A, 5'd0,  7'd0,   1'b1, 8'h00, 8'h00, 5'd2, 7'd0},
		// clear keeps the cursor and blanks the cells just written
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_CLEAR,  8'h0A, 5'd0,  7'd0,   1'b1, 8'h00, 8'h00, 5'd2, 7'd0},
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_READ,   8'h00, 5'd0,  7'd1,   1'b1, 8'h20, 8'h00, 5'd2, 7'd0},
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_READ,   8'h00, 5'd1,  7'd0,   1'b1, 8'h20, 8'h00, 5'd2, 7'd0},
		// mid-range colours, the rest left to the predictor
		'{1'b1, CFG_FOREGROUND, 4'd9,  ACT_PUT,    8'h00, 5'd0,  7'd0,   1'b0, 8'h00, 8'h00, 5'd0, 7'd0},
		'{1'b1, CFG_BACKGROUND, 4'd6,  ACT_PUT,    8'h00, 5'd0,  7'd0,   1'b0, 8'h00, 8'h00, 5'd0, 7'd0},
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_PUT,    8'h7F, 5'd0,  7'd0,   1'b0, 8'h00, 8'h00, 5'd0, 7'd0},
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_PUT,    8'h80, 5'd0,  7'd0,   1'b0, 8'h00, 8'h00, 5'd0, 7'd0},
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_READ,   8'h00, 5'd2,  7'd0,   1'b0, 8'h00, 8'h00, 5'd0, 7'd0},
		'{1'b0, CFG_FOREGROUND, 4'd0,  ACT_READ,   8'h00, 5'd2,  7'd1,   1'b0, 8'h00, 8'h00, 5'd0, 7'd0}
	};

	// main sequence: reset, directed rows, then random phases under new colours
	initial begin
		cell_report_t hand_rep;
		int unsigned  k;
		int unsigned  phase_no;
		logic [3:0]   fg;
		logic [3:0]   bg;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = ACT_PUT;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_FOREGROUND;
		cfg_data   = '0;
		blank_rows(0, ROWS - 1);
		cursor_r   = 0;
		cursor_c   = 0;
		fg_nibble  = 4'd15;
		bg_nibble  = 4'd0;
		beats_sent = 0;
		burst_left = 0;
		beat_offered   = 1'b0;
		colour_offered = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// the dut blanks its store after reset with s_tready low, so the first
		// beat simply waits on the handshake
		for (k = 0; k < $size(directed_steps); k++) begin
			if (directed_steps[k].is_cfg) begin
				wait_for_results();
				write_colour(directed_steps[k].cfg_sel, directed_steps[k].cfg_val);
			end else begin
				hand_rep.chr    = directed_steps[k].e_chr;
				hand_rep.colour = directed_steps[k].e_colour;
				hand_rep.row    = directed_steps[k].e_row;
				hand_rep.col    = directed_steps[k].e_col;
				send_beat(directed_steps[k].act, directed_steps[k].chr,
				          directed_steps[k].rrow, directed_steps[k].rcol,
				          directed_steps[k].typed, hand_rep);
			end
		end

		// colours change only with the pipe empty; first both at 0, then both at 15
		for (phase_no = 0; phase_no < 8; phase_no++) begin
			wait_for_results();
			case (phase_no)
				0: begin
					fg = 4'd0;
					bg = 4'd0;
				end
				1: begin
					fg = 4'd15;
					bg = 4'd15;
				end
				default: begin
					fg = 4'($urandom);
					bg = 4'($urandom);
				end
			endcase
			write_colour(CFG_FOREGROUND, fg);
			write_colour(CFG_BACKGROUND, bg);
			// scenes run past the target by a few dozen beats on average
			run_random(beats_sent + 50);
		end

		wait_for_results();
		repeat (16) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_text_console_writer_unit OK");
		end else begin
			$display("tb_text_console_writer_unit NOT OK");
		end
		$finish;
	end

	// ------------------------------------------------------------------
	// output side
	// ------------------------------------------------------------------

	// receiver back-pressure: a 16-bit mask rotated every cycle and reloaded at the end of
	// each random window; windows of full speed, random stalls and near total stalls
	initial begin
		logic [15:0] ready_mask;
		int unsigned window;
		m_tready   = 1'b0;
		ready_mask = 16'hFFFF;
		window     = 0;
		forever begin
			@(posedge clk);
			if (window == 0) begin
				case ($urandom_range(0, 3))
					0: ready_mask = 16'hFFFF;
					1: ready_mask = 16'($urandom);
					2: ready_mask = 16'($urandom) | 16'($urandom);
					default: ready_mask = 16'h8000;
				endcase
				window = $urandom_range(32, 96);
			end
			window--;
			m_tready   <= ready_mask[0];
			ready_mask = {ready_mask[0], ready_mask[15:1]};
		end
	end

	// every result beat is checked against the oldest outstanding expectation
	always @(posedge clk) begin
		cell_report_t got;
		cell_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[27:0];
			if (pending_reports.size() == 0) begin
				$display("%0t: result beat with nothing outstanding, got %h", $time, got);
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				if (got.chr !== want.chr) begin
					$display("%0t: cell_char expected %h got %h", $time, want.chr, got.chr);
					mismatches++;
				end
				if (got.colour !== want.colour) begin
					$display("%0t: cell_colour expected %h got %h", $time, want.colour,
					         got.colour);
					mismatches++;
				end
				if (got.row !== want.row) begin
					$display("%0t: cursor_row expected %0d got %0d", $time, want.row, got.row);
					mismatches++;
				end
				if (got.col !== want.col) begin
					$display("%0t: cursor_col expected %0d got %0d", $time, want.col, got.col);
					mismatches++;
				end
			end
		end
	end

	// watchdog: cycles in a row with no beat on any channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, quiet_cycles);
			$display("tb_text_console_writer_unit NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		mismatches   = 0;
		quiet_cycles = 0;
	end

endmodule

// ----- sim.f -----
rtl/core/tcw_pkg.sv
rtl/core/tcw_cell_store.sv
rtl/core/text_console_writer_unit.sv
rtl/core/tcw_checker.sv
dv/tb_text_console_writer_unit.sv
